// File: design/ccks_pkg.sv
`default_nettype none
package ccks_pkg;

  // ChaCha constant words ("expand 32-byte k")
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam int unsigned BLOCK_BYTES   = 64;
  localparam int unsigned BLOCK_WORDS   = 16;
  localparam int unsigned WORD_W        = $clog2(BLOCK_WORDS);
  localparam int unsigned POS_W         = $clog2(BLOCK_BYTES) + 1;
  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_INDEX_W   = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_01   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_23   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_45   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_67   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_01 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_2  = 3'd5;

  // input commands
  localparam logic CMD_DRAW    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_ROUND,
    ST_STORE,
    ST_FETCH,
    ST_EMIT
  } ccks_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load_work;
    logic              round_en;
    logic [1:0]        step;
    logic              diag;
    logic              store_en;
    logic [WORD_W-1:0] word;
    logic              ctr_clear;
    logic              ctr_incr;
    logic              rd_en;
    logic              emit;
    logic [1:0]        byte_sel;
    logic              last;
  } ccks_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } ccks_status_t;

  // state word of a lane: row 0..3, column shifted by the row on diagonal halves
  function automatic logic [WORD_W-1:0] lane_idx(input logic [1:0] row,
                                                  input logic [1:0] lane,
                                                  input logic       diag);
    logic [1:0] col;
    col = diag ? 2'(lane + row) : lane;
    return {row, col};
  endfunction

  // rotate amount of each quarter-round line: 16, 12, 8, 7
  function automatic logic [31:0] rot_step(input logic [31:0] v, input logic [1:0] step);
    logic [31:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/chacha20_keystream_bytes.sv
`default_nettype none
// ChaCha20 keystream byte source. Load the key and nonce through the config port
// while idle, then send draw transactions of 0 to 64 bytes; each byte comes out as
// one output transaction, in order, with last_byte on the final one. A restart
// transaction zeroes the block counter and discards the buffered keystream.
// Timing: a draw is taken only when the block is idle. Each byte goes through the
// check, buffer read and output load states, as the 16 x 32 keystream buffer has
// one registered read port. Whenever the buffer runs empty a refill is inserted:
// a load state, round states doing one quarter-round line on all four lanes per
// cycle, and a store state writing one summed word per cycle into the buffer.
module chacha20_keystream_bytes #(
  parameter int unsigned DOUBLE_ROUNDS = ccks_pkg::DOUBLE_ROUNDS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ccks_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ccks_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic                             cmd,
  input  wire logic [6:0]                       byte_count,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [7:0]                       data_byte,
  output      logic                             last_byte,
  output      logic                             key_nonzero
);

  ccks_pkg::ccks_cmd_t    dp_cmd;
  ccks_pkg::ccks_status_t dp_status;

  ccks_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .byte_count(byte_count),
    .cmd_out   (dp_cmd),
    .status    (dp_status)
  );

  ccks_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_in     (dp_cmd),
    .status     (dp_status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .key_nonzero(key_nonzero)
  );

endmodule
`default_nettype wire

// File: design/ccks_ram.sv
`default_nettype none
module ccks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/ccks_datapath.sv
`default_nettype none
module ccks_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [ccks_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ccks_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire ccks_pkg::ccks_cmd_t                 cmd_in,
  output      ccks_pkg::ccks_status_t              status,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [7:0]                          data_byte,
  output      logic                                last_byte,
  output      logic                                key_nonzero
);

  logic [63:0] key_01, key_23, key_45, key_67, nonce_01;
  logic [31:0] nonce_2;
  logic [31:0] block_counter;
  logic [31:0] init_w    [ccks_pkg::BLOCK_WORDS];
  logic [31:0] work      [ccks_pkg::BLOCK_WORDS];
  logic [31:0] work_next [ccks_pkg::BLOCK_WORDS];
  logic [31:0] rd_data;
  logic [31:0] wr_data;
  logic        any_key;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_01   <= '0;
      key_23   <= '0;
      key_45   <= '0;
      key_67   <= '0;
      nonce_01 <= '0;
      nonce_2  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ccks_pkg::CFG_KEY_01:   key_01   <= cfg_data;
        ccks_pkg::CFG_KEY_23:   key_23   <= cfg_data;
        ccks_pkg::CFG_KEY_45:   key_45   <= cfg_data;
        ccks_pkg::CFG_KEY_67:   key_67   <= cfg_data;
        ccks_pkg::CFG_NONCE_01: nonce_01 <= cfg_data;
        ccks_pkg::CFG_NONCE_2:  nonce_2  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign any_key = |{key_01, key_23, key_45, key_67};

  // block counter, wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (rst || cmd_in.ctr_clear) begin
      block_counter <= '0;
    end else if (cmd_in.ctr_incr) begin
      block_counter <= block_counter + 32'd1;
    end
  end

  // input state of the block
  always_comb begin
    init_w[0]  = ccks_pkg::SIGMA_0;
    init_w[1]  = ccks_pkg::SIGMA_1;
    init_w[2]  = ccks_pkg::SIGMA_2;
    init_w[3]  = ccks_pkg::SIGMA_3;
    init_w[4]  = key_01[31:0];
    init_w[5]  = key_01[63:32];
    init_w[6]  = key_23[31:0];
    init_w[7]  = key_23[63:32];
    init_w[8]  = key_45[31:0];
    init_w[9]  = key_45[63:32];
    init_w[10] = key_67[31:0];
    init_w[11] = key_67[63:32];
    init_w[12] = block_counter;
    init_w[13] = nonce_01[31:0];
    init_w[14] = nonce_01[63:32];
    init_w[15] = nonce_2;
  end

  // one line of the quarter round on all four lanes at once
  always_comb begin
    logic [ccks_pkg::WORD_W-1:0] ia, ib, ic, id;
    logic [31:0]                 sum;
    work_next = work;
    for (int j = 0; j < 4; j++) begin
      ia = ccks_pkg::lane_idx(2'd0, 2'(j), cmd_in.diag);
      ib = ccks_pkg::lane_idx(2'd1, 2'(j), cmd_in.diag);
      ic = ccks_pkg::lane_idx(2'd2, 2'(j), cmd_in.diag);
      id = ccks_pkg::lane_idx(2'd3, 2'(j), cmd_in.diag);
      if (!cmd_in.step[0]) begin
        sum           = work[ia] + work[ib];
        work_next[ia] = sum;
        work_next[id] = ccks_pkg::rot_step(work[id] ^ sum, cmd_in.step);
      end else begin
        sum           = work[ic] + work[id];
        work_next[ic] = sum;
        work_next[ib] = ccks_pkg::rot_step(work[ib] ^ sum, cmd_in.step);
      end
    end
  end

  // working state
  always_ff @(posedge clk) begin
    if (cmd_in.load_work) begin
      work <= init_w;
    end else if (cmd_in.round_en) begin
      work <= work_next;
    end
  end

  // feed-forward add, one word per cycle into the buffer
  assign wr_data = work[cmd_in.word] + init_w[cmd_in.word];

  ccks_ram #(
    .WIDTH(32),
    .DEPTH(ccks_pkg::BLOCK_WORDS)
  ) u_buffer (
    .clk  (clk),
    .we   (cmd_in.store_en),
    .waddr(cmd_in.word),
    .wdata(wr_data),
    .re   (cmd_in.rd_en),
    .raddr(cmd_in.word),
    .rdata(rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_in.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.emit) begin
      data_byte   <= 8'(rd_data >> {cmd_in.byte_sel, 3'b000});
      last_byte   <= cmd_in.last;
      key_nonzero <= any_key;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

// File: design/ccks_ctrl.sv
`default_nettype none
module ccks_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = ccks_pkg::DOUBLE_ROUNDS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic                   cmd,
  input  wire logic [6:0]             byte_count,
  output      ccks_pkg::ccks_cmd_t    cmd_out,
  input  wire ccks_pkg::ccks_status_t status
);

  localparam int unsigned TOTAL_STEPS = DOUBLE_ROUNDS * 8;
  localparam int unsigned STEP_W      = $clog2(TOTAL_STEPS);
  localparam int unsigned POS_W       = ccks_pkg::POS_W;

  ccks_pkg::ccks_state_t           state, state_next;
  logic [POS_W-1:0]                read_pos, read_pos_next;
  logic [POS_W-1:0]                remaining, remaining_next;
  logic [STEP_W-1:0]               step_cnt, step_cnt_next;
  logic [ccks_pkg::WORD_W-1:0]     word_idx, word_idx_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccks_pkg::ST_IDLE;
      read_pos  <= POS_W'(ccks_pkg::BLOCK_BYTES);
      remaining <= '0;
      step_cnt  <= '0;
      word_idx  <= '0;
    end else begin
      state     <= state_next;
      read_pos  <= read_pos_next;
      remaining <= remaining_next;
      step_cnt  <= step_cnt_next;
      word_idx  <= word_idx_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    read_pos_next  = read_pos;
    remaining_next = remaining;
    step_cnt_next  = step_cnt;
    word_idx_next  = word_idx;
    cmd_out        = '0;
    cmd_out.step     = step_cnt[1:0];
    cmd_out.diag     = step_cnt[2];
    cmd_out.word     = word_idx;
    cmd_out.byte_sel = read_pos[1:0];
    cmd_out.last     = (remaining == POS_W'(1));
    in_stall       = (state != ccks_pkg::ST_IDLE);

    case (state)
      ccks_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (cmd == ccks_pkg::CMD_RESTART) begin
            cmd_out.ctr_clear = 1'b1;
            read_pos_next     = POS_W'(ccks_pkg::BLOCK_BYTES);
          end else if (byte_count != '0) begin
            // oversized draws saturate to one block
            remaining_next = (byte_count > 7'(ccks_pkg::BLOCK_BYTES)) ?
                             POS_W'(ccks_pkg::BLOCK_BYTES) : POS_W'(byte_count);
            state_next     = ccks_pkg::ST_CHECK;
          end
        end
      end
      ccks_pkg::ST_CHECK: begin
        state_next = read_pos[POS_W-1] ? ccks_pkg::ST_LOAD : ccks_pkg::ST_FETCH;
      end
      ccks_pkg::ST_LOAD: begin
        cmd_out.load_work = 1'b1;
        step_cnt_next     = '0;
        state_next        = ccks_pkg::ST_ROUND;
      end
      ccks_pkg::ST_ROUND: begin
        cmd_out.round_en = 1'b1;
        step_cnt_next    = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(TOTAL_STEPS - 1)) begin
          word_idx_next = '0;
          state_next    = ccks_pkg::ST_STORE;
        end
      end
      ccks_pkg::ST_STORE: begin
        cmd_out.store_en = 1'b1;
        word_idx_next    = word_idx + ccks_pkg::WORD_W'(1);
        if (word_idx == ccks_pkg::WORD_W'(ccks_pkg::BLOCK_WORDS - 1)) begin
          cmd_out.ctr_incr = 1'b1;
          read_pos_next    = '0;
          state_next       = ccks_pkg::ST_CHECK;
        end
      end
      ccks_pkg::ST_FETCH: begin
        cmd_out.rd_en = 1'b1;
        cmd_out.word  = read_pos[ccks_pkg::WORD_W+1:2];
        state_next    = ccks_pkg::ST_EMIT;
      end
      ccks_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd_out.emit   = 1'b1;
          read_pos_next  = read_pos + POS_W'(1);
          remaining_next = remaining - POS_W'(1);
          state_next     = (remaining == POS_W'(1)) ? ccks_pkg::ST_IDLE : ccks_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = ccks_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: verif/chacha20_keystream_bytes_tb.sv
`timescale 1ns / 1ps

module chacha20_keystream_bytes_tb;

  // indexes outside the register map, writes to them must be ignored
  localparam logic [ccks_pkg::CFG_INDEX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [ccks_pkg::CFG_INDEX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       nz;
  } ks_byte_t;

  // keystream predictor and store of bytes still owed by the block
  class keystream_scoreboard;
    logic [63:0] key01, key23, key45, key67, nonce01;
    logic [31:0] nonce2;
    logic [31:0] blk_ctr;
    logic [7:0]  ks_buf [ccks_pkg::BLOCK_BYTES];
    logic [31:0] work [ccks_pkg::BLOCK_WORDS];
    int unsigned rd_pos;
    ks_byte_t    owed [$];
    int errors, bytes_checked, draws, restarts, blocks;

    function new();
      key01 = '0; key23 = '0; key45 = '0; key67 = '0;
      nonce01 = '0; nonce2 = '0;
      blk_ctr = '0;
      rd_pos = ccks_pkg::BLOCK_BYTES;
      errors = 0; bytes_checked = 0; draws = 0; restarts = 0; blocks = 0;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(input logic [ccks_pkg::CFG_INDEX_W-1:0] idx,
                          input logic [63:0] val);
      case (idx)
        ccks_pkg::CFG_KEY_01:   key01 = val;
        ccks_pkg::CFG_KEY_23:   key23 = val;
        ccks_pkg::CFG_KEY_45:   key45 = val;
        ccks_pkg::CFG_KEY_67:   key67 = val;
        ccks_pkg::CFG_NONCE_01: nonce01 = val;
        ccks_pkg::CFG_NONCE_2:  nonce2 = val[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void quarter(input int a, input int b, input int c, input int d);
      work[a] += work[b]; work[d] ^= work[a]; work[d] = rotl(work[d], 16);
      work[c] += work[d]; work[b] ^= work[c]; work[b] = rotl(work[b], 12);
      work[a] += work[b]; work[d] ^= work[a]; work[d] = rotl(work[d], 8);
      work[c] += work[d]; work[b] ^= work[c]; work[b] = rotl(work[b], 7);
    endfunction

    // one ChaCha block from the current key, counter and nonce
    function void refill_block();
      logic [31:0] init_w [ccks_pkg::BLOCK_WORDS];
      logic [31:0] v;
      init_w[0]  = ccks_pkg::SIGMA_0;
      init_w[1]  = ccks_pkg::SIGMA_1;
      init_w[2]  = ccks_pkg::SIGMA_2;
      init_w[3]  = ccks_pkg::SIGMA_3;
      init_w[4]  = key01[31:0];
      init_w[5]  = key01[63:32];
      init_w[6]  = key23[31:0];
      init_w[7]  = key23[63:32];
      init_w[8]  = key45[31:0];
      init_w[9]  = key45[63:32];
      init_w[10] = key67[31:0];
      init_w[11] = key67[63:32];
      init_w[12] = blk_ctr;
      init_w[13] = nonce01[31:0];
      init_w[14] = nonce01[63:32];
      init_w[15] = nonce2;
      work = init_w;
      for (int r = 0; r < ccks_pkg::DOUBLE_ROUNDS; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      // little-endian store of the summed words
      for (int i = 0; i < ccks_pkg::BLOCK_WORDS; i++) begin
        v = work[i] + init_w[i];
        ks_buf[4*i]   = v[7:0];
        ks_buf[4*i+1] = v[15:8];
        ks_buf[4*i+2] = v[23:16];
        ks_buf[4*i+3] = v[31:24];
      end
      blk_ctr = blk_ctr + 32'd1;
      rd_pos = 0;
      blocks++;
    endfunction

    // accepted input transaction: queue the bytes it produces
    function void note_input(input logic c, input logic [6:0] n);
      int unsigned cnt;
      ks_byte_t b;
      if (c == ccks_pkg::CMD_RESTART) begin
        blk_ctr = '0;
        rd_pos = ccks_pkg::BLOCK_BYTES;
        restarts++;
        return;
      end
      draws++;
      cnt = (n > ccks_pkg::BLOCK_BYTES) ? ccks_pkg::BLOCK_BYTES : n;
      for (int unsigned i = 0; i < cnt; i++) begin
        if (rd_pos >= ccks_pkg::BLOCK_BYTES) refill_block();
        b.data = ks_buf[rd_pos];
        b.last = (i + 1 == cnt);
        b.nz = |(key01 | key23 | key45 | key67);
        rd_pos++;
        owed.push_back(b);
      end
    endfunction

    // accepted output transaction against the oldest owed byte
    task check_result(input logic [7:0] d, input logic l, input logic nz);
      ks_byte_t b;
      if (owed.size() == 0) begin
        report($sformatf("unexpected byte %02h", d));
        return;
      end
      b = owed.pop_front();
      if (d !== b.data)
        report($sformatf("byte %0d: data_byte %02h, want %02h", bytes_checked, d, b.data));
      if (l !== b.last)
        report($sformatf("byte %0d: last_byte %b, want %b", bytes_checked, l, b.last));
      if (nz !== b.nz)
        report($sformatf("byte %0d: key_nonzero %b, want %b", bytes_checked, nz, b.nz));
      bytes_checked++;
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [ccks_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ccks_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             cmd = ccks_pkg::CMD_DRAW;
  logic [6:0]                       byte_count = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [7:0]                       data_byte;
  logic                             last_byte;
  logic                             key_nonzero;

  keystream_scoreboard sb = new();
  int items_sent = 0;

  chacha20_keystream_bytes u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .byte_count  (byte_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .key_nonzero (key_nonzero)
  );

  always #5 clk = ~clk;

  // one register write, called at a rising edge; caller drops cfg_write afterwards
  task automatic write_reg(input logic [ccks_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // offer one input transaction after a random gap, return once accepted
  task automatic send_item(input logic c, input logic [6:0] n);
    int gap;
    gap = (items_sent % 32 < 8) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    byte_count <= n;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, n);
    items_sent++;
  endtask

  task automatic send_random_item();
    int pick;
    logic [6:0] n;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item(ccks_pkg::CMD_RESTART, 7'($urandom));
    end else begin
      if (pick < 13)      n = 7'd0;
      else if (pick < 18) n = 7'($urandom_range(65, 127));
      else if (pick < 60) n = 7'($urandom_range(1, 16));
      else                n = 7'($urandom_range(17, 64));
      send_item(ccks_pkg::CMD_DRAW, n);
    end
  endtask

  // wait for all owed bytes, then let a possible refill or restart finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // register settings for one random phase
  task automatic configure_phase(input int mode);
    int which;
    case (mode)
      0: begin
        write_reg(ccks_pkg::CFG_KEY_01, {$urandom, $urandom});
        write_reg(ccks_pkg::CFG_KEY_23, {$urandom, $urandom});
        write_reg(ccks_pkg::CFG_KEY_45, {$urandom, $urandom});
        write_reg(ccks_pkg::CFG_KEY_67, {$urandom, $urandom});
        write_reg(ccks_pkg::CFG_NONCE_01, {$urandom, $urandom});
        write_reg(ccks_pkg::CFG_NONCE_2, {$urandom, $urandom});
      end
      1: begin
        // a single nonzero key register
        which = $urandom_range(0, 3);
        write_reg(ccks_pkg::CFG_KEY_01,
                  (which == 0) ? {$urandom, $urandom} | 64'd1 : 64'd0);
        write_reg(ccks_pkg::CFG_KEY_23,
                  (which == 1) ? {$urandom, $urandom} | 64'd1 : 64'd0);
        write_reg(ccks_pkg::CFG_KEY_45,
                  (which == 2) ? {$urandom, $urandom} | 64'd1 : 64'd0);
        write_reg(ccks_pkg::CFG_KEY_67,
                  (which == 3) ? {$urandom, $urandom} | 64'd1 : 64'd0);
        write_reg(ccks_pkg::CFG_NONCE_01, {$urandom, $urandom});
      end
      default: begin
        // all-zero key, random nonce
        write_reg(ccks_pkg::CFG_KEY_01, 64'd0);
        write_reg(ccks_pkg::CFG_KEY_23, 64'd0);
        write_reg(ccks_pkg::CFG_KEY_45, 64'd0);
        write_reg(ccks_pkg::CFG_KEY_67, 64'd0);
        write_reg(ccks_pkg::CFG_NONCE_2, {$urandom, $urandom});
      end
    endcase
    if ($urandom_range(0, 1))
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});
    cfg_write <= 1'b0;
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: all-zero key and nonce
    send_item(ccks_pkg::CMD_DRAW, 7'd1);
    send_item(ccks_pkg::CMD_DRAW, 7'd64);      // crosses a block boundary
    send_item(ccks_pkg::CMD_DRAW, 7'd0);       // empty draw
    send_item(ccks_pkg::CMD_DRAW, 7'd65);      // oversized, saturates
    send_item(ccks_pkg::CMD_DRAW, 7'd127);
    send_item(ccks_pkg::CMD_RESTART, 7'd127);  // count ignored
    send_item(ccks_pkg::CMD_DRAW, 7'd3);
    send_item(ccks_pkg::CMD_RESTART, 7'd0);
    send_item(ccks_pkg::CMD_DRAW, 7'd64);
    send_item(ccks_pkg::CMD_DRAW, 7'd5);       // leaves the buffer part used
    settle();

    // all-ones settings while the buffer still holds old keystream
    write_reg(ccks_pkg::CFG_KEY_01, '1);
    write_reg(ccks_pkg::CFG_KEY_23, '1);
    write_reg(ccks_pkg::CFG_KEY_45, '1);
    write_reg(ccks_pkg::CFG_KEY_67, '1);
    write_reg(ccks_pkg::CFG_NONCE_01, '1);
    write_reg(ccks_pkg::CFG_NONCE_2, '1);
    cfg_write <= 1'b0;
    send_item(ccks_pkg::CMD_DRAW, 7'd64);
    send_item(ccks_pkg::CMD_DRAW, 7'd10);
    settle();

    // writes to unmapped indexes must change nothing
    write_reg(CFG_SPARE_6, {$urandom, $urandom});
    write_reg(CFG_SPARE_7, {$urandom, $urandom});
    cfg_write <= 1'b0;
    send_item(ccks_pkg::CMD_DRAW, 7'd60);
    send_item(ccks_pkg::CMD_RESTART, 7'd64);
    send_item(ccks_pkg::CMD_DRAW, 7'd2);

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      configure_phase(ph % 3);
      repeat (36) send_random_item();
    end
    settle();

    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d bytes never arrived", sb.owed.size()));
    $display("Covered %0d draws and %0d restarts, %0d keystream blocks over 8 settings.",
             sb.draws, sb.restarts, sb.blocks);
    $display("Checked %0d output bytes, %0d errors.", sb.bytes_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stall per byte, bursts without stall, one long hold-off
  initial begin : result_side
    int hold;
    bit long_done;
    hold = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(data_byte, last_byte, key_nonzero);
        if (!long_done && sb.bytes_checked == 1200) begin
          hold = 700;
          long_done = 1'b1;
        end else if (sb.bytes_checked % 60 < 15) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, 12);
        end
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
